// File: design/assert_macros.svh
// ============================================================================
// Assertion macros
// Shared concurrent assertion forms for the soil moisture datapath. Defining
// NO_ASSERTIONS turns every use into empty text.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

// File: design/smrd_pkg.sv
// ============================================================================
// Soil moisture from radar delay: shared definitions
// Field widths, status codes, Q31.32 coefficients and the sideband type that
// travels with each word through the pipeline.
// ============================================================================
package smrd_pkg;

    localparam int BIN_COUNT_DEF = 512;
    localparam int DEPTH_W       = 22;
    localparam int SOIL_W        = 3;
    localparam int WC_W          = 19;
    localparam int ST_W          = 2;
    localparam int Q_W           = 64;
    localparam int BINLEN_W      = 44;
    localparam int WC_SHIFT      = 16;
    localparam int MAC_LAT       = 4;
    localparam int WC_POS_MAG    = 262143;
    localparam int WC_NEG_MAG    = 262144;

    typedef logic signed [Q_W-1:0] q_t;

    typedef struct packed {
        logic [1:0]      soil;
        logic [ST_W-1:0] st;
    } side_t;

    localparam logic [ST_W-1:0]   ST_OK         = 2'd0;
    localparam logic [ST_W-1:0]   ST_BAD_SOIL   = 2'd1;
    localparam logic [ST_W-1:0]   ST_ZERO_DEPTH = 2'd2;
    localparam logic [SOIL_W-1:0] SOIL_LAST     = 3'd3;

    localparam q_t Q_MAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam q_t Q_ONE   = 64'sh0000_0001_0000_0000;
    localparam q_t X_SCALE = 64'sh0000_0000_0010_0000;

    localparam logic signed [WC_W-1:0] WC_MAX_VAL = 19'sh3FFFF;
    localparam logic signed [WC_W-1:0] WC_MIN_VAL = 19'sh40000;
    localparam logic signed [WC_W-1:0] WC_NEG_ONE = 19'sh70000;

    // Rounds mant * 10^-dexp * 2^shift half up by long division.
    function automatic logic [63:0] dec_fixed(input logic neg, input logic [63:0] mant,
                                              input int dexp, input int shift);
        logic [63:0]  d;
        logic [63:0]  r;
        logic [127:0] q;
        logic         nb;
        d = 64'd1;
        for (int i = 0; i < dexp; i++)
        begin
            d = d * 64'd10;
        end
        r = '0;
        q = '0;
        for (int i = 0; i < 64 + shift; i++)
        begin
            if (i < 64)
            begin
                nb = mant[63 - i];
            end
            else
            begin
                nb = 1'b0;
            end
            r = {r[62:0], nb};
            q = {q[126:0], 1'b0};
            if (r >= d)
            begin
                r    = r - d;
                q[0] = 1'b1;
            end
        end
        if (r >= d - r)
        begin
            q = q + 128'd1;
        end
        return neg ? (64'd0 - q[63:0]) : q[63:0];
    endfunction

    localparam logic [BINLEN_W-1:0] BINLEN_MAG =
        BINLEN_W'(dec_fixed(1'b0, 64'd3790984152165, 9, 32));

    localparam q_t RAW_C3 = q_t'(dec_fixed(1'b0, 64'd1018, 5, 32));
    localparam q_t RAW_C2 = q_t'(dec_fixed(1'b1, 64'd1479, 3, 32));
    localparam q_t RAW_C1 = q_t'(dec_fixed(1'b0, 64'd7747, 2, 32));
    localparam q_t RAW_C0 = q_t'(dec_fixed(1'b0, 64'd1711, 0, 32));

    localparam q_t SOIL_C3 [4] = '{
        q_t'(dec_fixed(1'b0, 64'd512018081, 18, 68)),
        q_t'(dec_fixed(1'b0, 64'd9079, 13, 68)),
        q_t'(dec_fixed(1'b1, 64'd3475, 13, 68)),
        q_t'(dec_fixed(1'b0, 64'd5916, 13, 68))
    };
    localparam q_t SOIL_C2 [4] = '{
        q_t'(dec_fixed(1'b1, 64'd3854251138, 15, 56)),
        q_t'(dec_fixed(1'b1, 64'd6626, 9, 56)),
        q_t'(dec_fixed(1'b0, 64'd2263, 9, 56)),
        q_t'(dec_fixed(1'b1, 64'd4536, 9, 56))
    };
    localparam q_t SOIL_C1 [4] = '{
        q_t'(dec_fixed(1'b0, 64'd9950433112, 12, 44)),
        q_t'(dec_fixed(1'b0, 64'd1643, 5, 44)),
        q_t'(dec_fixed(1'b1, 64'd4515, 6, 44)),
        q_t'(dec_fixed(1'b0, 64'd1183, 5, 44))
    };
    localparam q_t SOIL_C0 [4] = '{
        q_t'(dec_fixed(1'b1, 64'd8508168835941, 12, 32)),
        q_t'(dec_fixed(1'b1, 64'd1354, 2, 32)),
        q_t'(dec_fixed(1'b0, 64'd285, 2, 32)),
        q_t'(dec_fixed(1'b1, 64'd1017, 2, 32))
    };

endpackage

// File: design/smrd_mac.sv
// ============================================================================
// Saturating Q31.32 multiply-add
// Computes sat_add(sat_mul(a, x), c) in four register stages: magnitudes,
// four 32x32 partial products, rounding and saturation, signed add and clamp.
// ============================================================================
module smrd_mac
    import smrd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  side_t in_side,
    input  q_t    in_a,
    input  q_t    in_x,
    input  q_t    in_c,
    output logic  out_valid,
    output side_t out_side,
    output q_t    out_y,
    output q_t    out_x
);

    localparam logic signed [Q_W:0] SUM_HI = {1'b0, Q_MAX};
    localparam logic signed [Q_W:0] SUM_LO = -SUM_HI;

    logic [MAC_LAT-1:0] vld_reg;
    side_t              side_reg [MAC_LAT];
    q_t                 x_reg    [MAC_LAT];

    logic        st1_neg_reg;
    logic [63:0] st1_ua_reg;
    logic [63:0] st1_ub_reg;
    q_t          st1_c_reg;

    logic        st2_neg_reg;
    logic [63:0] st2_ll_reg;
    logic [63:0] st2_lh_reg;
    logic [63:0] st2_hl_reg;
    logic [63:0] st2_hh_reg;
    q_t          st2_c_reg;

    logic        st3_neg_reg;
    logic [63:0] st3_m_reg;
    q_t          st3_c_reg;

    q_t          st4_y_reg;

    logic [63:0] ua_next;
    logic [63:0] ub_next;
    logic [63:0] ll_next;
    logic [63:0] lh_next;
    logic [63:0] hl_next;
    logic [63:0] hh_next;
    logic [33:0] mid_next;
    logic [63:0] hi_next;
    logic [63:0] m_next;
    logic signed [Q_W:0] c65;
    logic signed [Q_W:0] m65;
    logic signed [Q_W:0] sum_next;
    q_t          y_next;

    assign ua_next = in_a[63] ? 64'(-in_a) : 64'(in_a);
    assign ub_next = in_x[63] ? 64'(-in_x) : 64'(in_x);

    assign ll_next = 64'(st1_ua_reg[31:0])  * 64'(st1_ub_reg[31:0]);
    assign lh_next = 64'(st1_ua_reg[31:0])  * 64'(st1_ub_reg[63:32]);
    assign hl_next = 64'(st1_ua_reg[63:32]) * 64'(st1_ub_reg[31:0]);
    assign hh_next = 64'(st1_ua_reg[63:32]) * 64'(st1_ub_reg[63:32]);

    assign mid_next = {2'b00, st2_ll_reg[63:32]} + {2'b00, st2_lh_reg[31:0]}
                    + {2'b00, st2_hl_reg[31:0]} + 34'(st2_ll_reg[31]);
    assign hi_next  = st2_hh_reg + {32'd0, st2_lh_reg[63:32]} + {32'd0, st2_hl_reg[63:32]}
                    + {62'd0, mid_next[33:32]};
    assign m_next   = (hi_next[63:31] != '0) ? 64'(Q_MAX) : {hi_next[31:0], mid_next[31:0]};

    assign c65      = {st3_c_reg[63], st3_c_reg};
    assign m65      = {1'b0, st3_m_reg};
    assign sum_next = st3_neg_reg ? (c65 - m65) : (c65 + m65);

    always_comb
    begin
        if (sum_next > SUM_HI)
        begin
            y_next = Q_MAX;
        end
        else if (sum_next < SUM_LO)
        begin
            y_next = -Q_MAX;
        end
        else
        begin
            y_next = sum_next[Q_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[MAC_LAT-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= in_side;
        x_reg[0]    <= in_x;
        for (int k = 1; k < MAC_LAT; k++)
        begin
            side_reg[k] <= side_reg[k-1];
            x_reg[k]    <= x_reg[k-1];
        end
        st1_neg_reg <= in_a[63] ^ in_x[63];
        st1_ua_reg  <= ua_next;
        st1_ub_reg  <= ub_next;
        st1_c_reg   <= in_c;
        st2_neg_reg <= st1_neg_reg;
        st2_ll_reg  <= ll_next;
        st2_lh_reg  <= lh_next;
        st2_hl_reg  <= hl_next;
        st2_hh_reg  <= hh_next;
        st2_c_reg   <= st1_c_reg;
        st3_neg_reg <= st2_neg_reg;
        st3_m_reg   <= m_next;
        st3_c_reg   <= st2_c_reg;
        st4_y_reg   <= y_next;
    end

    assign out_valid = vld_reg[MAC_LAT-1];
    assign out_side  = side_reg[MAC_LAT-1];
    assign out_x     = x_reg[MAC_LAT-1];
    assign out_y     = st4_y_reg;

endmodule

// File: design/soil_moisture_from_radar_delay_unit.sv
// ============================================================================
// Soil moisture from radar delay
// Turns the wet and air echo bins of a buried tag, its depth and the soil type
// into volumetric water content through permittivity and a raw sensor count.
// ============================================================================
//
// Channel   Ports                                        Handshake
// -------   ------------------------------------------   ---------------------
// input     wet_bin, air_bin, depth_um, soil_type         start high, busy low
// result    water_content, status                         done high one cycle
//
// One word enters every cycle; busy is always low.
// The pipeline runs through the input registers, the 4-bit-per-stage divider,
// the ratio register, eight 4-stage multiply-add units and the output registers.
// Reset clears every valid bit; payload registers are not reset.
// Results are never held back: each word leaves on done in the cycle it is ready.
// ============================================================================
`include "assert_macros.svh"

module soil_moisture_from_radar_delay_unit
    import smrd_pkg::*;
#(
    parameter int BIN_COUNT = BIN_COUNT_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [$clog2(BIN_COUNT)-1:0]  wet_bin,
    input  logic [$clog2(BIN_COUNT)-1:0]  air_bin,
    input  logic [DEPTH_W-1:0]            depth_um,
    input  logic [SOIL_W-1:0]             soil_type,
    output logic                          done,
    output logic signed [WC_W-1:0]        water_content,
    output logic [ST_W-1:0]               status
);

    localparam int BIN_W      = $clog2(BIN_COUNT);
    localparam int NUM_W      = BIN_W + BINLEN_W;
    localparam int DVD_W      = NUM_W + 1;
    localparam int DIV_BITS   = 4;
    localparam int DIV_STAGES = (DVD_W + DIV_BITS - 1) / DIV_BITS;
    localparam int DVD_PAD    = DIV_STAGES * DIV_BITS;
    localparam int MAC_COUNT  = 8;
    localparam int M_W        = Q_W - WC_SHIFT;
    localparam int LATENCY    = 3 + DIV_STAGES + 1 + MAC_COUNT * MAC_LAT + 2;
    localparam logic [BIN_W-1:0] BIN_MAX = BIN_W'(BIN_COUNT - 1);

    logic [BIN_W-1:0] wet_c;
    logic [BIN_W-1:0] air_c;
    logic [ST_W-1:0]  st_next;

    logic               s1_v_reg;
    logic               s1_neg_reg;
    logic [BIN_W-1:0]   s1_mag_reg;
    logic [DEPTH_W-1:0] s1_depth_reg;
    side_t              s1_side_reg;

    logic               s2_v_reg;
    logic               s2_neg_reg;
    logic [NUM_W-1:0]   s2_num_reg;
    logic [DEPTH_W-1:0] s2_depth_reg;
    side_t              s2_side_reg;

    logic               s3_v_reg;
    logic               s3_neg_reg;
    logic [DVD_W-1:0]   s3_dvd_reg;
    logic [DEPTH_W-1:0] s3_depth_reg;
    side_t              s3_side_reg;

    logic               div_v_reg    [DIV_STAGES];
    logic [DVD_PAD-1:0] div_w_reg    [DIV_STAGES];
    logic [DEPTH_W-1:0] div_r_reg    [DIV_STAGES];
    logic [DEPTH_W-1:0] div_d_reg    [DIV_STAGES];
    logic               div_neg_reg  [DIV_STAGES];
    side_t              div_side_reg [DIV_STAGES];

    logic               rt_v_reg;
    q_t                 rt_ratio_reg;
    side_t              rt_side_reg;
    logic [Q_W-1:0]     q64;
    q_t                 ratio_next;

    logic  mac_vi [MAC_COUNT];
    logic  mac_vo [MAC_COUNT];
    side_t mac_si [MAC_COUNT];
    side_t mac_so [MAC_COUNT];
    q_t    mac_a  [MAC_COUNT];
    q_t    mac_x  [MAC_COUNT];
    q_t    mac_c  [MAC_COUNT];
    q_t    mac_y  [MAC_COUNT];
    q_t    mac_xo [MAC_COUNT];

    logic               f1_v_reg;
    logic               f1_neg_reg;
    logic [Q_W-1:0]     f1_mag_reg;
    side_t              f1_side_reg;
    logic [Q_W-1:0]     rnd_sum;
    logic [M_W-1:0]     m_round;
    logic [WC_W-1:0]    m_low;
    logic signed [WC_W-1:0] wc_calc;
    logic signed [WC_W-1:0] wc_next;

    logic                   done_reg;
    logic signed [WC_W-1:0] water_content_reg;
    logic [ST_W-1:0]        status_reg;

    assign busy = 1'b0;

    // Input stages: clamp, signed bin difference and status, bin length product, rounding addend.
    assign wet_c = (wet_bin > BIN_MAX) ? BIN_MAX : wet_bin;
    assign air_c = (air_bin > BIN_MAX) ? BIN_MAX : air_bin;

    always_comb
    begin
        if (soil_type > SOIL_LAST)
        begin
            st_next = ST_BAD_SOIL;
        end
        else if (depth_um == '0)
        begin
            st_next = ST_ZERO_DEPTH;
        end
        else
        begin
            st_next = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= start && !busy;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_neg_reg   <= air_c > wet_c;
        s1_mag_reg   <= (air_c > wet_c) ? (air_c - wet_c) : (wet_c - air_c);
        s1_depth_reg <= depth_um;
        s1_side_reg  <= '{soil: soil_type[1:0], st: st_next};
        s2_neg_reg   <= s1_neg_reg;
        s2_num_reg   <= NUM_W'(s1_mag_reg) * NUM_W'(BINLEN_MAG);
        s2_depth_reg <= s1_depth_reg;
        s2_side_reg  <= s1_side_reg;
        s3_neg_reg   <= s2_neg_reg;
        s3_dvd_reg   <= DVD_W'(s2_num_reg) + DVD_W'(s2_depth_reg >> 1);
        s3_depth_reg <= s2_depth_reg;
        s3_side_reg  <= s2_side_reg;
    end

    // Restoring divider, DIV_BITS quotient bits per stage.
    for (genvar s = 0; s < DIV_STAGES; s++)
    begin : g_div
        logic               v_in;
        logic [DVD_PAD-1:0] w_in;
        logic [DEPTH_W-1:0] r_in;
        logic [DEPTH_W-1:0] d_in;
        logic               neg_in;
        side_t              side_in;
        logic [DVD_PAD-1:0] w_next;
        logic [DEPTH_W-1:0] r_next;
        logic [DEPTH_W:0]   trial;

        if (s == 0)
        begin : g_first
            assign v_in    = s3_v_reg;
            assign w_in    = DVD_PAD'(s3_dvd_reg);
            assign r_in    = '0;
            assign d_in    = s3_depth_reg;
            assign neg_in  = s3_neg_reg;
            assign side_in = s3_side_reg;
        end
        else
        begin : g_rest
            assign v_in    = div_v_reg[s-1];
            assign w_in    = div_w_reg[s-1];
            assign r_in    = div_r_reg[s-1];
            assign d_in    = div_d_reg[s-1];
            assign neg_in  = div_neg_reg[s-1];
            assign side_in = div_side_reg[s-1];
        end

        always_comb
        begin
            w_next = w_in;
            r_next = r_in;
            trial  = '0;
            for (int k = 0; k < DIV_BITS; k++)
            begin
                trial  = {r_next, w_next[DVD_PAD-1]};
                w_next = {w_next[DVD_PAD-2:0], 1'b0};
                if (trial >= {1'b0, d_in})
                begin
                    trial     = trial - {1'b0, d_in};
                    w_next[0] = 1'b1;
                end
                r_next = trial[DEPTH_W-1:0];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                div_v_reg[s] <= 1'b0;
            end
            else
            begin
                div_v_reg[s] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            div_w_reg[s]    <= w_next;
            div_r_reg[s]    <= r_next;
            div_d_reg[s]    <= d_in;
            div_neg_reg[s]  <= neg_in;
            div_side_reg[s] <= side_in;
        end
    end

    // Depth ratio in Q31.32.
    assign q64        = Q_W'(div_w_reg[DIV_STAGES-1]);
    assign ratio_next = div_neg_reg[DIV_STAGES-1] ? (Q_ONE - $signed(q64))
                                                  : (Q_ONE + $signed(q64));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rt_v_reg <= 1'b0;
        end
        else
        begin
            rt_v_reg <= div_v_reg[DIV_STAGES-1];
        end
    end

    always_ff @(posedge clk)
    begin
        rt_ratio_reg <= ratio_next;
        rt_side_reg  <= div_side_reg[DIV_STAGES-1];
    end

    // Permittivity, raw count cubic, scaling and soil cubic.
    assign mac_vi[0] = rt_v_reg;
    assign mac_si[0] = rt_side_reg;
    assign mac_a[0]  = rt_ratio_reg;
    assign mac_x[0]  = rt_ratio_reg;
    assign mac_c[0]  = '0;

    assign mac_a[1]  = RAW_C3;
    assign mac_x[1]  = mac_y[0];
    assign mac_c[1]  = RAW_C2;
    assign mac_a[2]  = mac_y[1];
    assign mac_x[2]  = mac_xo[1];
    assign mac_c[2]  = RAW_C1;
    assign mac_a[3]  = mac_y[2];
    assign mac_x[3]  = mac_xo[2];
    assign mac_c[3]  = RAW_C0;

    assign mac_a[4]  = mac_y[3];
    assign mac_x[4]  = X_SCALE;
    assign mac_c[4]  = '0;

    assign mac_a[5]  = SOIL_C3[mac_so[4].soil];
    assign mac_x[5]  = mac_y[4];
    assign mac_c[5]  = SOIL_C2[mac_so[4].soil];
    assign mac_a[6]  = mac_y[5];
    assign mac_x[6]  = mac_xo[5];
    assign mac_c[6]  = SOIL_C1[mac_so[5].soil];
    assign mac_a[7]  = mac_y[6];
    assign mac_x[7]  = mac_xo[6];
    assign mac_c[7]  = SOIL_C0[mac_so[6].soil];

    for (genvar k = 0; k < MAC_COUNT; k++)
    begin : g_mac
        if (k > 0)
        begin : g_link
            assign mac_vi[k] = mac_vo[k-1];
            assign mac_si[k] = mac_so[k-1];
        end

        smrd_mac u_mac
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (mac_vi[k]),
            .in_side   (mac_si[k]),
            .in_a      (mac_a[k]),
            .in_x      (mac_x[k]),
            .in_c      (mac_c[k]),
            .out_valid (mac_vo[k]),
            .out_side  (mac_so[k]),
            .out_y     (mac_y[k]),
            .out_x     (mac_xo[k])
        );
    end

    // Output rounding to Q2.16 with saturation.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_v_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            f1_v_reg <= mac_vo[MAC_COUNT-1];
            done_reg <= f1_v_reg;
        end
    end

    assign rnd_sum = f1_mag_reg + Q_W'(64'h8000);
    assign m_round = rnd_sum[Q_W-1:WC_SHIFT];
    assign m_low   = m_round[WC_W-1:0];

    always_comb
    begin
        if (f1_neg_reg)
        begin
            if (m_round > M_W'(WC_NEG_MAG))
            begin
                wc_calc = WC_MIN_VAL;
            end
            else
            begin
                wc_calc = $signed(WC_W'(0) - m_low);
            end
        end
        else
        begin
            if (m_round > M_W'(WC_POS_MAG))
            begin
                wc_calc = WC_MAX_VAL;
            end
            else
            begin
                wc_calc = $signed(m_low);
            end
        end
    end

    always_comb
    begin
        case (f1_side_reg.st)
            ST_OK:         wc_next = wc_calc;
            ST_BAD_SOIL:   wc_next = WC_NEG_ONE;
            ST_ZERO_DEPTH: wc_next = '0;
            default:       wc_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        f1_neg_reg        <= mac_y[MAC_COUNT-1][Q_W-1];
        f1_mag_reg        <= mac_y[MAC_COUNT-1][Q_W-1] ? Q_W'(-mac_y[MAC_COUNT-1])
                                                       : Q_W'(mac_y[MAC_COUNT-1]);
        f1_side_reg       <= mac_so[MAC_COUNT-1];
        water_content_reg <= wc_next;
        status_reg        <= f1_side_reg.st;
    end

    assign done          = done_reg;
    assign water_content = water_content_reg;
    assign status        = status_reg;

    `ASSERT_PROP(a_fixed_latency, clk, rst_n, start |-> ##LATENCY done, "accepted word did not complete on time")
    `ASSERT_PROP(a_no_spurious, clk, rst_n, done |-> $past(start, LATENCY), "result without an accepted word")
    `ASSERT_PROP(a_bad_soil, clk, rst_n, (start && (soil_type > SOIL_LAST)) |-> ##LATENCY (status == ST_BAD_SOIL && water_content == WC_NEG_ONE), "unknown soil word gave a wrong result")
    `ASSERT_PROP(a_zero_depth, clk, rst_n, (start && (soil_type <= SOIL_LAST) && (depth_um == '0)) |-> ##LATENCY (status == ST_ZERO_DEPTH && water_content == '0), "zero depth word gave a wrong result")
    `ASSERT_NEVER(a_status_code, clk, rst_n, done && status != ST_OK && status != ST_BAD_SOIL && status != ST_ZERO_DEPTH, "result carries an undefined status")

endmodule
